>>> design/thdu_pkg.sv
// shared types, widths and constants of the target heading and distance unit
package thdu_pkg;

    localparam int XW         = 36;    // cordic x/y datapath width
    localparam int PW         = 32;    // binary phase width
    localparam int RAD_W      = 66;    // squared distance width
    localparam int REM_W      = 35;    // square root remainder width
    localparam int ROOT_W     = 33;    // square root width
    localparam int SQRT_STEPS = 33;    // one result bit per cell
    localparam int UNIT_W     = 16;

    localparam logic [16:0]   TURN_UNITS = 17'd46080;
    localparam logic [PW-1:0] PH_90      = 32'h4000_0000;
    localparam logic [PW-1:0] PH_180     = 32'h8000_0000;

    localparam logic [1:0] REG_TARGET_X  = 2'd0;
    localparam logic [1:0] REG_TARGET_Y  = 2'd1;
    localparam logic [1:0] REG_STOP_DIST = 2'd2;

    // data held by one cell of the chain
    typedef struct packed {
        logic signed [XW-1:0] yaw_x;
        logic signed [XW-1:0] yaw_y;
        logic [PW-1:0]        yaw_z;
        logic                 yaw_zero;
        logic signed [XW-1:0] hd_x;
        logic signed [XW-1:0] hd_y;
        logic [PW-1:0]        hd_z;
        logic                 hd_zero;
        logic [RAD_W-1:0]     rad;
        logic [REM_W-1:0]     rem;
        logic [ROOT_W-1:0]    root;
    } t_cell_word;

    // atan(2^-i) as binary phase
    function automatic logic [PW-1:0] atan_at(input int i);
        logic [PW-1:0] a;
        case (i)
            0:  a = 32'h20000000;  1: a = 32'h12E4051E;  2: a = 32'h09FB385B;
            3:  a = 32'h051111D4;  4: a = 32'h028B0D43;  5: a = 32'h0145D7E1;
            6:  a = 32'h00A2F61E;  7: a = 32'h00517C55;  8: a = 32'h0028BE53;
            9:  a = 32'h00145F2F; 10: a = 32'h000A2F98; 11: a = 32'h000517CC;
            12: a = 32'h00028BE6; 13: a = 32'h000145F3; 14: a = 32'h0000A2F9;
            15: a = 32'h0000517C; 16: a = 32'h000028BE; 17: a = 32'h0000145F;
            18: a = 32'h00000A2F; 19: a = 32'h00000517; 20: a = 32'h0000028B;
            21: a = 32'h00000145; 22: a = 32'h000000A2; 23: a = 32'h00000051;
            24: a = 32'h00000028; 25: a = 32'h00000014; 26: a = 32'h0000000A;
            27: a = 32'h00000005; 28: a = 32'h00000002; 29: a = 32'h00000001;
            default: a = 32'h00000000;
        endcase
        return a;
    endfunction

endpackage

>>> design/thdu_cell.sv
// chain cell: one square root digit, cordic on both vectors in leading cells
module thdu_cell #(
    parameter int STAGE         = 0,
    parameter int CORDIC_STAGES = 24
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  thdu_pkg::t_cell_word i_data,
    output logic                o_valid,
    input  logic                i_ready,
    output thdu_pkg::t_cell_word o_data
);

    logic                 r_vld;
    thdu_pkg::t_cell_word r_data;
    thdu_pkg::t_cell_word n_data;
    logic [thdu_pkg::REM_W+1:0] w_rem_s;
    logic [thdu_pkg::REM_W+1:0] w_trial;

    assign o_ready = !r_vld || i_ready;
    assign o_valid = r_vld;
    assign o_data  = r_data;

    assign w_rem_s = {i_data.rem, i_data.rad[thdu_pkg::RAD_W-1 -: 2]};
    assign w_trial = {2'b00, i_data.root, 2'b01};

    always_comb begin
        n_data = i_data;
        if (STAGE < CORDIC_STAGES) begin
            if (!i_data.yaw_y[thdu_pkg::XW-1]) begin
                n_data.yaw_x = i_data.yaw_x + (i_data.yaw_y >>> STAGE);
                n_data.yaw_y = i_data.yaw_y - (i_data.yaw_x >>> STAGE);
                n_data.yaw_z = i_data.yaw_z + thdu_pkg::atan_at(STAGE);
            end else begin
                n_data.yaw_x = i_data.yaw_x - (i_data.yaw_y >>> STAGE);
                n_data.yaw_y = i_data.yaw_y + (i_data.yaw_x >>> STAGE);
                n_data.yaw_z = i_data.yaw_z - thdu_pkg::atan_at(STAGE);
            end
            if (!i_data.hd_y[thdu_pkg::XW-1]) begin
                n_data.hd_x = i_data.hd_x + (i_data.hd_y >>> STAGE);
                n_data.hd_y = i_data.hd_y - (i_data.hd_x >>> STAGE);
                n_data.hd_z = i_data.hd_z + thdu_pkg::atan_at(STAGE);
            end else begin
                n_data.hd_x = i_data.hd_x - (i_data.hd_y >>> STAGE);
                n_data.hd_y = i_data.hd_y + (i_data.hd_x >>> STAGE);
                n_data.hd_z = i_data.hd_z - thdu_pkg::atan_at(STAGE);
            end
        end
        // restoring square root digit
        n_data.rad = {i_data.rad[thdu_pkg::RAD_W-3:0], 2'b00};
        if (w_rem_s >= w_trial) begin
            n_data.rem  = thdu_pkg::REM_W'(w_rem_s - w_trial);
            n_data.root = {i_data.root[thdu_pkg::ROOT_W-2:0], 1'b1};
        end else begin
            n_data.rem  = w_rem_s[thdu_pkg::REM_W-1:0];
            n_data.root = {i_data.root[thdu_pkg::ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule

>>> design/target_heading_distance_unit.sv
// throughput: one word per cycle while the output is not stalled;
// every stage moves on its own ready, so bubbles fill
// stages: difference, squares and cordic setup, radicand sum, 33 chain cells, scale, round
// the chain length is set by the 33 square root digits, cordic uses the first cells
// reset (synchronous, active low) empties every stage and clears the three registers
module target_heading_distance_unit #(
    parameter int CORDIC_STAGES = 24
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    // input words
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // gps_coord_0[31:0], gps_coord_1[63:32], compass_x[79:64], compass_y[95:80]
    input  logic [95:0] s_axis_tdata,
    // result words
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // own_yaw[15:0], target_heading[31:16], target_distance[64:32], arrived[65], zero fill
    output logic [71:0] m_axis_tdata
);

    localparam int NCELL = thdu_pkg::SQRT_STEPS;

    // configuration registers
    logic signed [31:0] r_target_x;
    logic signed [31:0] r_target_y;
    logic [31:0]        r_stop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_x <= '0;
            r_target_y <= '0;
            r_stop     <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                thdu_pkg::REG_TARGET_X:  r_target_x <= i_cfg_data;
                thdu_pkg::REG_TARGET_Y:  r_target_y <= i_cfg_data;
                thdu_pkg::REG_STOP_DIST: r_stop     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // stage a: differences to target, x = gps1, y = -gps0
    logic               r_va;
    logic signed [33:0] r_dx;
    logic signed [33:0] r_dy;
    logic signed [15:0] r_kx;
    logic signed [15:0] r_ky;
    logic               w_rdy_a;

    // stage b: squares and cordic setup
    logic               r_vb;
    logic [thdu_pkg::RAD_W-1:0] r_sq_x;
    logic [thdu_pkg::RAD_W-1:0] r_sq_y;
    thdu_pkg::t_cell_word r_wb;
    logic               w_rdy_b;

    // stage c: radicand
    logic               r_vc;
    thdu_pkg::t_cell_word r_wc;
    thdu_pkg::t_cell_word n_wc;
    logic               w_rdy_c;

    // chain
    logic                 w_vld  [0:NCELL];
    logic                 w_rdy  [0:NCELL];
    thdu_pkg::t_cell_word w_data [0:NCELL];

    // stage f1: phase scaling
    logic        r_vf1;
    logic [47:0] r_yaw_p;
    logic [47:0] r_hd_p;
    logic [thdu_pkg::ROOT_W-1:0] r_dist_f1;
    logic        w_rdy_f1;

    // stage f2: rounding, wrap and output
    logic        r_vf2;
    logic [15:0] r_yaw;
    logic [15:0] r_head;
    logic [thdu_pkg::ROOT_W-1:0] r_dist;
    logic        r_arrived;
    logic        w_rdy_f2;

    logic [33:0] w_ax;
    logic [33:0] w_ay;
    logic [63:0] w_px;
    logic [63:0] w_py;
    logic [thdu_pkg::RAD_W-1:0] n_sq_x;
    logic [thdu_pkg::RAD_W-1:0] n_sq_y;
    thdu_pkg::t_cell_word n_wb;
    logic [31:0] w_yaw_ph;
    logic [31:0] w_hd_ph;
    logic [48:0] w_yaw_r;
    logic [48:0] w_hd_r;
    logic [16:0] w_yaw_u;
    logic [16:0] w_hd_u;

    // ready ripples back from the output
    assign w_rdy_f2      = !r_vf2 || m_axis_tready;
    assign w_rdy_f1      = !r_vf1 || w_rdy_f2;
    assign w_rdy[NCELL]  = w_rdy_f1;
    assign w_rdy_c       = !r_vc || w_rdy[0];
    assign w_rdy_b       = !r_vb || w_rdy_c;
    assign w_rdy_a       = !r_va || w_rdy_b;
    assign s_axis_tready = w_rdy_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
        end else if (w_rdy_a) begin
            r_va <= s_axis_tvalid;
        end
        if (w_rdy_a && s_axis_tvalid) begin
            r_dx <= 34'(r_target_x) - 34'(signed'(s_axis_tdata[63:32]));
            r_dy <= 34'(r_target_y) + 34'(signed'(s_axis_tdata[31:0]));
            r_kx <= s_axis_tdata[79:64];
            r_ky <= s_axis_tdata[95:80];
        end
    end

    // magnitudes reach 2^32 at most, whose square is handled apart
    assign w_ax = r_dx[33] ? 34'(-r_dx) : r_dx;
    assign w_ay = r_dy[33] ? 34'(-r_dy) : r_dy;
    // 32 by 32 products, upper operand halves are zero
    assign w_px = {32'd0, w_ax[31:0]} * {32'd0, w_ax[31:0]};
    assign w_py = {32'd0, w_ay[31:0]} * {32'd0, w_ay[31:0]};
    assign n_sq_x = w_ax[32] ? {2'b01, 64'd0} : {2'b00, w_px};
    assign n_sq_y = w_ay[32] ? {2'b01, 64'd0} : {2'b00, w_py};

    // cordic setup; the fixed yaw and heading offsets ride in z from the start
    always_comb begin
        n_wb = '0;
        n_wb.yaw_zero = (r_kx == 16'sd0) && (r_ky == 16'sd0);
        if (r_kx[15]) begin
            n_wb.yaw_x = -thdu_pkg::XW'(r_kx);
            n_wb.yaw_y = -thdu_pkg::XW'(r_ky);
            n_wb.yaw_z = thdu_pkg::PH_180 - thdu_pkg::PH_90;
        end else begin
            n_wb.yaw_x = thdu_pkg::XW'(r_kx);
            n_wb.yaw_y = thdu_pkg::XW'(r_ky);
            n_wb.yaw_z = 32'd0 - thdu_pkg::PH_90;
        end
        // heading vector is (dy, dx)
        n_wb.hd_zero = (r_dx == 34'sd0) && (r_dy == 34'sd0);
        if (r_dy[33]) begin
            n_wb.hd_x = -thdu_pkg::XW'(r_dy);
            n_wb.hd_y = -thdu_pkg::XW'(r_dx);
            n_wb.hd_z = thdu_pkg::PH_180 + thdu_pkg::PH_180;
        end else begin
            n_wb.hd_x = thdu_pkg::XW'(r_dy);
            n_wb.hd_y = thdu_pkg::XW'(r_dx);
            n_wb.hd_z = thdu_pkg::PH_180;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vb <= 1'b0;
        end else if (w_rdy_b) begin
            r_vb <= r_va;
        end
        if (w_rdy_b && r_va) begin
            r_sq_x <= n_sq_x;
            r_sq_y <= n_sq_y;
            r_wb   <= n_wb;
        end
    end

    always_comb begin
        n_wc     = r_wb;
        n_wc.rad = r_sq_x + r_sq_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vc <= 1'b0;
        end else if (w_rdy_c) begin
            r_vc <= r_vb;
        end
        if (w_rdy_c && r_vb) begin
            r_wc <= n_wc;
        end
    end

    assign w_vld[0]  = r_vc;
    assign w_data[0] = r_wc;

    // row of cells, one square root digit each, cordic on the leading ones
    for (genvar g = 0; g < NCELL; g++) begin : g_cell
        thdu_cell #(
            .STAGE         (g),
            .CORDIC_STAGES (CORDIC_STAGES)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_vld[g]),
            .o_ready (w_rdy[g]),
            .i_data  (w_data[g]),
            .o_valid (w_vld[g+1]),
            .i_ready (w_rdy[g+1]),
            .o_data  (w_data[g+1])
        );
    end

    // a zero vector has angle zero, leaving only the offset
    assign w_yaw_ph = w_data[NCELL].yaw_zero ? (32'd0 - thdu_pkg::PH_90)
                                              : w_data[NCELL].yaw_z;
    assign w_hd_ph  = w_data[NCELL].hd_zero ? thdu_pkg::PH_180 : w_data[NCELL].hd_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vf1 <= 1'b0;
        end else if (w_rdy_f1) begin
            r_vf1 <= w_vld[NCELL];
        end
        if (w_rdy_f1 && w_vld[NCELL]) begin
            r_yaw_p   <= w_yaw_ph * 16'(thdu_pkg::TURN_UNITS);
            r_hd_p    <= w_hd_ph * 16'(thdu_pkg::TURN_UNITS);
            r_dist_f1 <= w_data[NCELL].root;
        end
    end

    // round to the nearest 1/128 degree, a full turn wraps to zero
    assign w_yaw_r = {1'b0, r_yaw_p} + 49'h0_8000_0000;
    assign w_hd_r  = {1'b0, r_hd_p} + 49'h0_8000_0000;
    assign w_yaw_u = w_yaw_r[48:32];
    assign w_hd_u  = w_hd_r[48:32];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vf2 <= 1'b0;
        end else if (w_rdy_f2) begin
            r_vf2 <= r_vf1;
        end
        if (w_rdy_f2 && r_vf1) begin
            r_yaw     <= (w_yaw_u >= thdu_pkg::TURN_UNITS) ? 16'd0 : w_yaw_u[15:0];
            r_head    <= (w_hd_u >= thdu_pkg::TURN_UNITS) ? 16'd0 : w_hd_u[15:0];
            r_dist    <= r_dist_f1;
            r_arrived <= r_dist_f1 < {1'b0, r_stop};
        end
    end

    assign m_axis_tvalid = r_vf2;
    assign m_axis_tdata  = {6'd0, r_arrived, r_dist, r_head, r_yaw};

    // angles stay inside one turn
    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (r_yaw < 16'(thdu_pkg::TURN_UNITS))
                       && (r_head < 16'(thdu_pkg::TURN_UNITS)))
        else $error("angle out of range");

    // input is held back only when every stage is full and the output stalls
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
        else $error("input stalled with room in the pipeline");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result word after reset");

endmodule
